/* src/csl_pkg.sv */
// csl_pkg: shared types and codes for the C subset lexer.
// Depends on nothing; used by c_subset_lexer_unit.
`timescale 1ns / 1ps

package csl_pkg;

  // Scanner phase between bytes
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_IDENT,
    PH_NUMBER,
    PH_HELD,
    PH_SKIP
  } phase_t;

  // Token kinds
  localparam logic [3:0] KIND_IDENT  = 4'd0;
  localparam logic [3:0] KIND_NUMBER = 4'd1;
  localparam logic [3:0] KIND_OP     = 4'd2;
  localparam logic [3:0] KIND_RETURN = 4'd3;
  localparam logic [3:0] KIND_FOR    = 4'd4;
  localparam logic [3:0] KIND_WHILE  = 4'd5;
  localparam logic [3:0] KIND_IF     = 4'd6;
  localparam logic [3:0] KIND_EOF    = 4'd7;
  localparam logic [3:0] KIND_ERROR  = 4'd8;

  // Operator code field of a token that is not an operator
  localparam logic [3:0] OP_NONE = 4'd0;

  // Single-character operator codes
  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_SUB    = 4'd1;
  localparam logic [3:0] OP_MUL    = 4'd2;
  localparam logic [3:0] OP_DIV    = 4'd3;
  localparam logic [3:0] OP_LPAREN = 4'd4;
  localparam logic [3:0] OP_RPAREN = 4'd5;
  localparam logic [3:0] OP_LT     = 4'd6;
  localparam logic [3:0] OP_GT     = 4'd7;
  localparam logic [3:0] OP_ASSIGN = 4'd8;
  localparam logic [3:0] OP_SEMI   = 4'd9;
  localparam logic [3:0] OP_LBRACE = 4'd10;
  localparam logic [3:0] OP_RBRACE = 4'd11;

  // Two-character operator codes
  localparam logic [3:0] OP_NE = 4'd12;
  localparam logic [3:0] OP_EQ = 4'd13;
  localparam logic [3:0] OP_LE = 4'd14;
  localparam logic [3:0] OP_GE = 4'd15;

  localparam logic [15:0] POS_LIMIT = 16'hFFFF;
  localparam logic [7:0]  RUN_LIMIT = 8'd255;
  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

  // Result queue: eight entries; input held off once the count, plus two for
  // a byte in the input register, passes four
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam logic [QCNT_W-1:0] STALL_LEVEL = QCNT_W'(QUEUE_DEPTH - 4);

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  op;
    logic [15:0] start;
    logic [7:0]  len;
    logic [30:0] value;
    logic        ovf;
    logic        last;
  } tok_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] tok_begin;
    logic [7:0]  run_len;
    logic [30:0] acc;
    logic        sat;
    logic [3:0]  cand;
    logic [7:0]  held;
  } lex_state_t;

endpackage

/* src/c_subset_lexer_unit.sv */
// c_subset_lexer_unit: streaming lexer for a small C subset, one byte per beat.
// Depends on csl_pkg (types, token and operator codes).
//
// Usage:
//   Input channel (in_valid / in_stall / in_char_code) carries one source byte
//   per beat; byte 0 ends the text, emits EOF and restarts positions at 0.
//   Output channel (out_valid / out_stall / out_*) carries one token per beat;
//   out_last_of_run marks the final token caused by a given input byte.
//   An input beat is captured in an input register, the next cycle the scan
//   logic updates the lexer state and pushes 0, 1 or 2 tokens into an
//   8-entry result queue whose head drives the output ports.
//   Throughput: one byte per cycle while in_stall is low; a byte that closes a
//   token and emits another needs two output beats, so the output port sets the rate there.
//   in_stall rises once the queue count, plus two for a byte in the input
//   register, passes four; a new byte always finds room for its two tokens.
//   Reset (rst_n low, synchronous) empties the queue, drops any byte in
//   flight and returns the scanner to idle at byte position 0.
`timescale 1ns / 1ps

module c_subset_lexer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [3:0]  out_op_code,
  output logic [15:0] out_start_offset,
  output logic [7:0]  out_token_length,
  output logic [30:0] out_number_value,
  output logic        out_value_overflow,
  output logic        out_last_of_run
);

  // Keyword tables: 0 return, 1 for, 2 while, 3 if
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (k)
      2'd0: begin
        unique case (i)
          3'd0: ch = "r";
          3'd1: ch = "e";
          3'd2: ch = "t";
          3'd3: ch = "u";
          3'd4: ch = "r";
          3'd5: ch = "n";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (i)
          3'd0: ch = "f";
          3'd1: ch = "o";
          3'd2: ch = "r";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (i)
          3'd0: ch = "w";
          3'd1: ch = "h";
          3'd2: ch = "i";
          3'd3: ch = "l";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        unique case (i)
          3'd0: ch = "i";
          3'd1: ch = "f";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_len(input logic [1:0] k);
    logic [7:0] l;
    unique case (k)
      2'd0:    l = 8'd6;
      2'd1:    l = 8'd3;
      2'd2:    l = 8'd5;
      default: l = 8'd2;
    endcase
    return l;
  endfunction

  // Single-char operator code; bit 4 flags a match
  function automatic logic [4:0] single_op(input logic [7:0] ch);
    logic [4:0] r;
    unique case (ch)
      "+":     r = {1'b1, csl_pkg::OP_ADD};
      "-":     r = {1'b1, csl_pkg::OP_SUB};
      "*":     r = {1'b1, csl_pkg::OP_MUL};
      "/":     r = {1'b1, csl_pkg::OP_DIV};
      "(":     r = {1'b1, csl_pkg::OP_LPAREN};
      ")":     r = {1'b1, csl_pkg::OP_RPAREN};
      "<":     r = {1'b1, csl_pkg::OP_LT};
      ">":     r = {1'b1, csl_pkg::OP_GT};
      "=":     r = {1'b1, csl_pkg::OP_ASSIGN};
      ";":     r = {1'b1, csl_pkg::OP_SEMI};
      "{":     r = {1'b1, csl_pkg::OP_LBRACE};
      "}":     r = {1'b1, csl_pkg::OP_RBRACE};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic       in_accept;
  logic       pipe_v_r;
  logic [7:0] pipe_char_r;

  // ---------------------------------------------------------------------
  // Lexer state
  // ---------------------------------------------------------------------
  csl_pkg::lex_state_t st_r, st_nxt;
  logic [15:0]         pos_r, pos_nxt;

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  csl_pkg::tok_t                q_r [csl_pkg::QUEUE_DEPTH];
  logic [csl_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [csl_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                         pop;

  // Scan logic outputs
  csl_pkg::tok_t res0, res1;
  logic [1:0]    n_res;

  // Idle-path results (byte seen with no token pending)
  csl_pkg::lex_state_t idl_st;
  csl_pkg::tok_t       idl_tok;
  logic                idl_emit;
  logic                idl_eof;

  // Run growth
  logic [3:0]  grow_cand;
  logic [7:0]  grow_len;
  logic [34:0] mul10;
  logic [3:0]  ident_kind;

  logic [7:0]  c;
  logic        is_lower, is_digit, is_word, is_space;
  logic [4:0]  c_op, held_op;

  assign in_accept = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  // Conservative: room for two tokens from the byte in flight and two from a new one
  assign in_stall = (count_r + {{(csl_pkg::QCNT_W-2){1'b0}}, pipe_v_r, 1'b0})
                    > csl_pkg::STALL_LEVEL;

  assign c        = pipe_char_r;
  assign is_lower = (c >= "a") && (c <= "z");
  assign is_digit = (c >= "0") && (c <= "9");
  assign is_word  = is_lower || is_digit || ((c >= "A") && (c <= "Z")) || (c == "_");
  assign is_space = ((c >= 8'd9) && (c <= 8'd13)) || (c == " ");
  assign c_op     = single_op(c);
  assign held_op  = single_op(st_r.held);

  // acc * 10 + digit, 35 bits wide so a full accumulator cannot wrap
  assign mul10 = {1'b0, st_r.acc, 3'b000} + {3'b000, st_r.acc, 1'b0}
               + {31'd0, c[3:0]};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      grow_cand[k] = st_r.cand[k] && (st_r.run_len < kw_len(2'(k)))
                     && (kw_char(2'(k), st_r.run_len[2:0]) == c);
    end
    if (st_r.run_len < csl_pkg::RUN_LIMIT) begin
      grow_len = st_r.run_len + 8'd1;
    end else begin
      grow_len  = st_r.run_len;
      grow_cand = 4'd0;
    end
  end

  // Keyword match on a closed identifier
  always_comb begin
    ident_kind = csl_pkg::KIND_IDENT;
    for (int k = 0; k < 4; k++) begin
      if (st_r.cand[k] && (st_r.run_len == kw_len(2'(k)))) begin
        ident_kind = csl_pkg::KIND_RETURN + 4'(k);
      end
    end
  end

  // Idle path
  always_comb begin
    idl_st       = st_r;
    idl_st.phase = csl_pkg::PH_IDLE;
    idl_tok      = '0;
    idl_emit     = 1'b0;
    idl_eof      = 1'b0;
    if (c == 8'd0) begin
      idl_emit      = 1'b1;
      idl_eof       = 1'b1;
      idl_tok.kind  = csl_pkg::KIND_EOF;
      idl_tok.start = pos_r;
      idl_tok.len   = 8'd1;
    end else if (is_space) begin
      idl_emit = 1'b0;
    end else if (is_lower || is_digit) begin
      idl_st.phase     = is_lower ? csl_pkg::PH_IDENT : csl_pkg::PH_NUMBER;
      idl_st.tok_begin = pos_r;
      idl_st.run_len   = 8'd1;
      idl_st.sat       = 1'b0;
      idl_st.acc       = is_digit ? {27'd0, c[3:0]} : 31'd0;
      for (int k = 0; k < 4; k++) begin
        idl_st.cand[k] = (kw_char(2'(k), 3'd0) == c);
      end
    end else if ((c == "<") || (c == ">") || (c == "=") || (c == "!")) begin
      idl_st.phase     = csl_pkg::PH_HELD;
      idl_st.tok_begin = pos_r;
      idl_st.held      = c;
    end else if (c_op[4]) begin
      idl_emit      = 1'b1;
      idl_tok.kind  = csl_pkg::KIND_OP;
      idl_tok.op    = c_op[3:0];
      idl_tok.start = pos_r;
      idl_tok.len   = 8'd1;
    end else begin
      idl_st.phase  = csl_pkg::PH_SKIP;
      idl_emit      = 1'b1;
      idl_tok.kind  = csl_pkg::KIND_ERROR;
      idl_tok.start = pos_r;
      idl_tok.len   = 8'd1;
    end
  end

  // Main scan step
  always_comb begin
    st_nxt  = st_r;
    pos_nxt = (pos_r < csl_pkg::POS_LIMIT) ? pos_r + 16'd1 : pos_r;
    res0    = '0;
    res1    = '0;
    n_res   = 2'd0;

    unique case (st_r.phase)
      csl_pkg::PH_IDENT: begin
        if (is_word) begin
          st_nxt.cand    = grow_cand;
          st_nxt.run_len = grow_len;
        end else begin
          res0.kind  = ident_kind;
          res0.start = st_r.tok_begin;
          res0.len   = st_r.run_len;
          res1       = idl_tok;
          n_res      = idl_emit ? 2'd2 : 2'd1;
          st_nxt     = idl_st;
          if (idl_eof) begin
            pos_nxt = 16'd0;
          end
        end
      end
      csl_pkg::PH_NUMBER: begin
        if (is_digit) begin
          st_nxt.cand    = grow_cand;
          st_nxt.run_len = grow_len;
          if (mul10 > {4'b0000, csl_pkg::VALUE_MAX}) begin
            st_nxt.acc = csl_pkg::VALUE_MAX;
            st_nxt.sat = 1'b1;
          end else begin
            st_nxt.acc = mul10[30:0];
          end
        end else begin
          res0.kind  = csl_pkg::KIND_NUMBER;
          res0.start = st_r.tok_begin;
          res0.len   = st_r.run_len;
          res0.value = st_r.acc;
          res0.ovf   = st_r.sat;
          res1       = idl_tok;
          n_res      = idl_emit ? 2'd2 : 2'd1;
          st_nxt     = idl_st;
          if (idl_eof) begin
            pos_nxt = 16'd0;
          end
        end
      end
      csl_pkg::PH_HELD: begin
        res0.start = st_r.tok_begin;
        if (c == "=") begin
          res0.kind = csl_pkg::KIND_OP;
          priority if (st_r.held == "!") begin
            res0.op = csl_pkg::OP_NE;
          end else if (st_r.held == "=") begin
            res0.op = csl_pkg::OP_EQ;
          end else if (st_r.held == "<") begin
            res0.op = csl_pkg::OP_LE;
          end else begin
            res0.op = csl_pkg::OP_GE;
          end
          res0.len     = 8'd2;
          n_res        = 2'd1;
          st_nxt.phase = csl_pkg::PH_IDLE;
        end else if (st_r.held == "!") begin
          // lone bang: error, then skip to end of text
          res0.kind    = csl_pkg::KIND_ERROR;
          res0.len     = 8'd1;
          n_res        = 2'd1;
          st_nxt.phase = csl_pkg::PH_SKIP;
          if (c == 8'd0) begin
            res1.kind    = csl_pkg::KIND_EOF;
            res1.start   = pos_r;
            res1.len     = 8'd1;
            n_res        = 2'd2;
            st_nxt.phase = csl_pkg::PH_IDLE;
            pos_nxt      = 16'd0;
          end
        end else begin
          res0.kind = csl_pkg::KIND_OP;
          res0.op   = held_op[3:0];
          res0.len  = 8'd1;
          res1      = idl_tok;
          n_res     = idl_emit ? 2'd2 : 2'd1;
          st_nxt    = idl_st;
          if (idl_eof) begin
            pos_nxt = 16'd0;
          end
        end
      end
      csl_pkg::PH_SKIP: begin
        if (c == 8'd0) begin
          res0.kind    = csl_pkg::KIND_EOF;
          res0.start   = pos_r;
          res0.len     = 8'd1;
          n_res        = 2'd1;
          st_nxt.phase = csl_pkg::PH_IDLE;
          pos_nxt      = 16'd0;
        end
      end
      default: begin
        res0   = idl_tok;
        n_res  = idl_emit ? 2'd1 : 2'd0;
        st_nxt = idl_st;
        if (idl_eof) begin
          pos_nxt = 16'd0;
        end
      end
    endcase

    // Mark the final token of this byte
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  // Queue occupancy
  always_comb begin
    count_nxt = count_r;
    if (pipe_v_r) begin
      count_nxt = count_nxt + {{(csl_pkg::QCNT_W-2){1'b0}}, n_res};
    end
    if (pop) begin
      count_nxt = count_nxt - {{(csl_pkg::QCNT_W-1){1'b0}}, 1'b1};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r     <= 1'b0;
      st_r.phase   <= csl_pkg::PH_IDLE;
      st_r.tok_begin <= 16'd0;
      st_r.run_len <= 8'd0;
      st_r.acc     <= 31'd0;
      st_r.sat     <= 1'b0;
      st_r.cand    <= 4'd0;
      st_r.held    <= 8'd0;
      pos_r        <= 16'd0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      pipe_v_r <= in_accept;
      count_r  <= count_nxt;
      if (pipe_v_r) begin
        st_r     <= st_nxt;
        pos_r    <= pos_nxt;
        wr_ptr_r <= wr_ptr_r + csl_pkg::QPTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + csl_pkg::QPTR_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pipe_char_r <= in_char_code;
    end
    if (pipe_v_r && (n_res != 2'd0)) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (pipe_v_r && (n_res == 2'd2)) begin
      q_r[wr_ptr_r + csl_pkg::QPTR_W'(1)] <= res1;
    end
  end

  // Queue head drives the output beat
  assign out_valid          = (count_r != '0);
  assign out_token_kind     = q_r[rd_ptr_r].kind;
  assign out_op_code        = q_r[rd_ptr_r].op;
  assign out_start_offset   = q_r[rd_ptr_r].start;
  assign out_token_length   = q_r[rd_ptr_r].len;
  assign out_number_value   = q_r[rd_ptr_r].value;
  assign out_value_overflow = q_r[rd_ptr_r].ovf;
  assign out_last_of_run    = q_r[rd_ptr_r].last;

endmodule

/* dv/lex_token_monitor.sv */
// lex_token_monitor: watches both channels of c_subset_lexer_unit, predicts each token
// from the accepted source bytes and compares every output beat against it.
// Depends on csl_pkg (tok_t, phase_t, token and operator codes, limits).
`timescale 1ns / 1ps

module lex_token_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_token_kind,
  input  logic [3:0]  out_op_code,
  input  logic [15:0] out_start_offset,
  input  logic [7:0]  out_token_length,
  input  logic [30:0] out_number_value,
  input  logic        out_value_overflow,
  input  logic        out_last_of_run,
  output int          error_count,
  output int          tokens_pending,
  output int          tokens_checked
);

  // scanner copy
  csl_pkg::phase_t scan_ph;
  logic [15:0]     next_pos;
  logic [15:0]     tok_start;
  logic [7:0]      run_len;
  logic [30:0]     acc;
  logic            sat;
  logic [3:0]      cand;
  logic [7:0]      held_ch;

  csl_pkg::tok_t tokens_due[$];
  int   fails = 0;
  int   checked = 0;
  int   due_count = 0;

  assign error_count    = fails;
  assign tokens_pending = due_count;
  assign tokens_checked = checked;

  function automatic logic [7:0] kw_char(input int k, input int i);
    logic [47:0] w;
    case (k)
      0:       w = "return";
      1:       w = {"for", 24'h0};
      2:       w = {"while", 8'h0};
      default: w = {"if", 32'h0};
    endcase
    if (i > 5) return 8'h0;
    return w[47-8*i -: 8];
  endfunction

  function automatic int kw_len(input int k);
    case (k)
      0:       return 6;
      1:       return 3;
      2:       return 5;
      default: return 2;
    endcase
  endfunction

  function automatic logic [3:0] kw_kind(input int k);
    case (k)
      0:       return csl_pkg::KIND_RETURN;
      1:       return csl_pkg::KIND_FOR;
      2:       return csl_pkg::KIND_WHILE;
      default: return csl_pkg::KIND_IF;
    endcase
  endfunction

  function automatic bit is_word(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic bit single_op(input logic [7:0] c, output logic [3:0] code);
    code = csl_pkg::OP_NONE;
    case (c)
      "+":     code = csl_pkg::OP_ADD;
      "-":     code = csl_pkg::OP_SUB;
      "*":     code = csl_pkg::OP_MUL;
      "/":     code = csl_pkg::OP_DIV;
      "(":     code = csl_pkg::OP_LPAREN;
      ")":     code = csl_pkg::OP_RPAREN;
      "<":     code = csl_pkg::OP_LT;
      ">":     code = csl_pkg::OP_GT;
      "=":     code = csl_pkg::OP_ASSIGN;
      ";":     code = csl_pkg::OP_SEMI;
      "{":     code = csl_pkg::OP_LBRACE;
      "}":     code = csl_pkg::OP_RBRACE;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic string tok_text(input csl_pkg::tok_t t);
    return $sformatf("kind=%0d op=%0d start=%0d len=%0d value=%0d ovf=%0b last=%0b",
                     t.kind, t.op, t.start, t.len, t.value, t.ovf, t.last);
  endfunction

  task automatic put_tok(input logic [3:0] kind, input logic [3:0] op,
                         input logic [15:0] start, input logic [7:0] len,
                         input logic [30:0] value, input logic ovf);
    csl_pkg::tok_t t;
    t.kind  = kind;
    t.op    = op;
    t.start = start;
    t.len   = len;
    t.value = value;
    t.ovf   = ovf;
    t.last  = 1'b0;
    tokens_due.push_back(t);
  endtask

  task automatic begin_run(input csl_pkg::phase_t ph, input logic [15:0] p);
    scan_ph   = ph;
    tok_start = p;
    run_len   = 8'd0;
    acc       = 31'd0;
    sat       = 1'b0;
    cand      = 4'hF;
  endtask

  // keyword candidates drop out as soon as a byte disagrees
  task automatic grow_run(input logic [7:0] c);
    for (int k = 0; k < 4; k++)
      if (run_len >= kw_len(k) || kw_char(k, run_len) != c) cand[k] = 1'b0;
    if (run_len < csl_pkg::RUN_LIMIT) run_len++;
    else cand = 4'h0;
  endtask

  task automatic close_text(input logic [15:0] p);
    put_tok(csl_pkg::KIND_EOF, csl_pkg::OP_NONE, p, 8'd1, 31'd0, 1'b0);
    scan_ph  = csl_pkg::PH_IDLE;
    next_pos = 16'd0;
  endtask

  // byte arriving with no token open
  task automatic fresh_byte(input logic [7:0] c, input logic [15:0] p);
    logic [3:0] code;
    scan_ph = csl_pkg::PH_IDLE;
    if (c == 8'd0) begin
      close_text(p);
    end else if ((c >= 8'd9 && c <= 8'd13) || c == " ") begin
    end else if (c >= "a" && c <= "z") begin
      begin_run(csl_pkg::PH_IDENT, p);
      grow_run(c);
    end else if (c >= "0" && c <= "9") begin
      begin_run(csl_pkg::PH_NUMBER, p);
      grow_run(c);
      acc = {23'd0, c - "0"};
    end else if (c == "<" || c == ">" || c == "=" || c == "!") begin
      scan_ph   = csl_pkg::PH_HELD;
      tok_start = p;
      held_ch   = c;
    end else if (single_op(c, code)) begin
      put_tok(csl_pkg::KIND_OP, code, p, 8'd1, 31'd0, 1'b0);
    end else begin
      scan_ph = csl_pkg::PH_SKIP;
      put_tok(csl_pkg::KIND_ERROR, csl_pkg::OP_NONE, p, 8'd1, 31'd0, 1'b0);
    end
  endtask

  task automatic lex_byte(input logic [7:0] c);
    int            n0;
    logic [15:0]   p;
    logic [63:0]   v;
    logic [3:0]    kind;
    logic [3:0]    code;
    csl_pkg::tok_t t;
    n0 = tokens_due.size();
    p  = next_pos;
    if (next_pos < csl_pkg::POS_LIMIT) next_pos++;
    case (scan_ph)
      csl_pkg::PH_IDENT: begin
        if (is_word(c)) begin
          grow_run(c);
        end else begin
          kind = csl_pkg::KIND_IDENT;
          for (int k = 0; k < 4; k++)
            if (cand[k] && run_len == kw_len(k)) kind = kw_kind(k);
          put_tok(kind, csl_pkg::OP_NONE, tok_start, run_len, 31'd0, 1'b0);
          fresh_byte(c, p);
        end
      end
      csl_pkg::PH_NUMBER: begin
        if (c >= "0" && c <= "9") begin
          v = 64'(acc);
          v = v * 10 + (c - "0");
          grow_run(c);
          if (v > csl_pkg::VALUE_MAX) begin
            v   = 64'(csl_pkg::VALUE_MAX);
            sat = 1'b1;
          end
          acc = v[30:0];
        end else begin
          put_tok(csl_pkg::KIND_NUMBER, csl_pkg::OP_NONE, tok_start, run_len, acc, sat);
          fresh_byte(c, p);
        end
      end
      csl_pkg::PH_HELD: begin
        if (c == "=") begin
          code = held_ch == "!" ? csl_pkg::OP_NE :
                 held_ch == "=" ? csl_pkg::OP_EQ :
                 held_ch == "<" ? csl_pkg::OP_LE : csl_pkg::OP_GE;
          put_tok(csl_pkg::KIND_OP, code, tok_start, 8'd2, 31'd0, 1'b0);
          scan_ph = csl_pkg::PH_IDLE;
        end else if (held_ch == "!") begin
          // lone bang: error, then skip to end of text
          put_tok(csl_pkg::KIND_ERROR, csl_pkg::OP_NONE, tok_start, 8'd1, 31'd0, 1'b0);
          scan_ph = csl_pkg::PH_SKIP;
          if (c == 8'd0) close_text(p);
        end else begin
          void'(single_op(held_ch, code));
          put_tok(csl_pkg::KIND_OP, code, tok_start, 8'd1, 31'd0, 1'b0);
          fresh_byte(c, p);
        end
      end
      csl_pkg::PH_SKIP: begin
        if (c == 8'd0) close_text(p);
      end
      default: fresh_byte(c, p);
    endcase
    if (tokens_due.size() > n0) begin
      t = tokens_due.pop_back();
      t.last = 1'b1;
      tokens_due.push_back(t);
    end
  endtask

  always @(posedge clk) begin : watch
    csl_pkg::tok_t got;
    csl_pkg::tok_t want;
    if (!rst_n) begin
      scan_ph   = csl_pkg::PH_IDLE;
      next_pos  = 16'd0;
      tok_start = 16'd0;
      run_len   = 8'd0;
      acc       = 31'd0;
      sat       = 1'b0;
      cand      = 4'h0;
      held_ch   = 8'd0;
      tokens_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.kind  = out_token_kind;
        got.op    = out_op_code;
        got.start = out_start_offset;
        got.len   = out_token_length;
        got.value = out_number_value;
        got.ovf   = out_value_overflow;
        got.last  = out_last_of_run;
        if (tokens_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected token, expected none, got %s", $time, tok_text(got));
        end else begin
          want = tokens_due.pop_front();
          checked++;
          if (got !== want) begin
            fails++;
            $display("%0t: token mismatch, expected %s, got %s",
                     $time, tok_text(want), tok_text(got));
          end
        end
      end
      if (in_valid && !in_stall) lex_byte(in_char_code);
    end
    due_count = tokens_due.size();
  end

endmodule

/* dv/tb_top.sv */
// tb_top: stimulus and verdict for c_subset_lexer_unit.
// Depends on csl_pkg, c_subset_lexer_unit and lex_token_monitor (prediction, compare).
`timescale 1ns / 1ps

module tb_top;

  // A whole run with no beat on either channel for this long means the block hung.
  // Longest legal quiet stretch is the forced output hold below plus a random
  // stall run, well under this.
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int MIX_BYTES   = 175;
  localparam int DRAIN_WAIT  = 10;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_code;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_token_kind;
  logic [3:0]  out_op_code;
  logic [15:0] out_start_offset;
  logic [7:0]  out_token_length;
  logic [30:0] out_number_value;
  logic        out_value_overflow;
  logic        out_last_of_run;

  int fails;
  int pending;
  int checked;

  int gap_pct   = 0;    // chance per cycle the source sits idle before a beat
  int stall_pct = 0;    // chance per cycle the sink stalls
  bit long_hold = 1'b0; // sink holds off HOLD_CYCLES once after this is set
  int bytes_sent = 0;
  int quiet = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  c_subset_lexer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_token_kind     (out_token_kind),
    .out_op_code        (out_op_code),
    .out_start_offset   (out_start_offset),
    .out_token_length   (out_token_length),
    .out_number_value   (out_number_value),
    .out_value_overflow (out_value_overflow),
    .out_last_of_run    (out_last_of_run)
  );

  lex_token_monitor token_monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_token_kind     (out_token_kind),
    .out_op_code        (out_op_code),
    .out_start_offset   (out_start_offset),
    .out_token_length   (out_token_length),
    .out_number_value   (out_number_value),
    .out_value_overflow (out_value_overflow),
    .out_last_of_run    (out_last_of_run),
    .error_count        (fails),
    .tokens_pending     (pending),
    .tokens_checked     (checked)
  );

  // One source byte per beat. Idle cycles go in front of the beat; valid only
  // drops during a gap, so a back-to-back beat never toggles it in one step.
  // Returns right after the accepting rising edge.
  task automatic send_byte(input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_chars(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // letters of both cases, digits and underscore: keeps a word token open
  function automatic logic [7:0] word_char();
    case ($urandom_range(3))
      0:       return 8'("a" + $urandom_range(25));
      1:       return 8'("A" + $urandom_range(25));
      2:       return 8'("0" + $urandom_range(9));
      default: return "_";
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    if ($urandom_range(2) == 0) return " ";
    return 8'(8'd9 + $urandom_range(4));
  endfunction

  function automatic string keyword_text();
    case ($urandom_range(3))
      0:       return "return";
      1:       return "for";
      2:       return "while";
      default: return "if";
    endcase
  endfunction

  // One text ending in byte 0. Mostly a sequence of well-formed tokens with
  // random spacing (adjacent tokens glue, e.g. "<" "=" or number-then-word),
  // sometimes a lone bang or junk byte that sends the block into skip mode,
  // and now and then a text of pure noise.
  task automatic send_random_text();
    int    ntok;
    int    r;
    int    len;
    string kw;
    ntok = $urandom_range(12);
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(1, 8);
      repeat (len) send_byte(8'($urandom_range(1, 255)));
      send_byte(8'd0);
      return;
    end
    repeat (ntok) begin
      r = $urandom_range(99);
      if (r < 22) begin
        send_byte(8'("a" + $urandom_range(25)));
        len = $urandom_range(8);
        repeat (len) send_byte(word_char());
      end else if (r < 34) begin
        // exact keyword, keyword minus its tail, or keyword plus one more char
        kw = keyword_text();
        case ($urandom_range(3))
          0, 1: send_chars(kw);
          2:    send_chars(kw.substr(0, kw.len() - 2));
          default: begin
            send_chars(kw);
            send_byte(word_char());
          end
        endcase
      end else if (r < 50) begin
        // occasional long numbers to push the value past 2^31-1
        len = ($urandom_range(7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 6);
        repeat (len) send_byte(8'("0" + $urandom_range(9)));
      end else if (r < 80) begin
        case ($urandom_range(15))
          0:  send_byte("+");
          1:  send_byte("-");
          2:  send_byte("*");
          3:  send_byte("/");
          4:  send_byte("(");
          5:  send_byte(")");
          6:  send_byte("<");
          7:  send_byte(">");
          8:  send_byte("=");
          9:  send_byte(";");
          10: send_byte("{");
          11: send_byte("}");
          12: send_chars("!=");
          13: send_chars("==");
          14: send_chars("<=");
          default: send_chars(">=");
        endcase
      end else if (r < 84) begin
        send_byte("!");
      end else if (r < 87) begin
        send_byte(8'($urandom_range(1, 255)));
      end else begin
        send_byte(blank_char());
      end
      if ($urandom_range(1)) send_byte(blank_char());
    end
    send_byte(8'd0);
  endtask

  // Sink side. A long hold is counted out here, independent of the source,
  // so the result queue fills and in_stall has to come up.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        hold_done = 1'b1;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Hang detector: counts cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = 8'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: keywords, glued number and word, != pair, lone bang,
    // underscore at token start, top byte value.
    send_chars("if(a!=b)return 12ab;");
    send_byte(8'd0);
    send_chars("!x");
    send_byte(8'd0);
    send_byte("_");
    send_byte(8'hFF);
    send_byte(8'd0);

    // Random texts under four traffic mixes. The first mix opens with a long
    // sink hold while the source keeps offering bytes.
    for (int mix = 0; mix < 4; mix++) begin
      int mix_end;
      case (mix)
        0: begin gap_pct = 0;  stall_pct = 0;  long_hold = 1'b1; end
        1: begin gap_pct = 52; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 52; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase
      mix_end = bytes_sent + MIX_BYTES;
      while (bytes_sent < mix_end) send_random_text();
    end

    // Runs longer than the length counter: an identifier that starts like a
    // keyword and a number, both past 255 bytes.
    gap_pct   = 0;
    stall_pct = 12;
    send_chars("while");
    repeat (260) send_byte(word_char());
    send_byte(" ");
    repeat (260) send_byte(8'("0" + $urandom_range(9)));
    send_byte(8'd0);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("tb: %0d source bytes sent, %0d tokens checked", bytes_sent, checked);
    $display("tb: covered four traffic mixes, a long sink hold and oversize runs");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
src/csl_pkg.sv
src/c_subset_lexer_unit.sv
dv/lex_token_monitor.sv
dv/tb_top.sv
